// ----- design/dzr_pkg.sv -----
`timescale 1ns / 1ps

package dzr_pkg;

	// Store geometry and element width.
	localparam int MAX_ROWS   = 16;
	localparam int MAX_COLS   = 16;
	localparam int VALUE_BITS = 32;
	localparam int ROW_BITS   = 4;
	localparam int COL_BITS   = 4;
	localparam int ADDR_BITS  = ROW_BITS + COL_BITS;
	localparam int COUNT_BITS = 5;
	localparam int CFG_IDX_BITS = 2;

	// Item function codes.
	localparam logic [1:0] FUNC_LOAD    = 2'd0;
	localparam logic [1:0] FUNC_READ    = 2'd1;
	localparam logic [1:0] FUNC_RESTART = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_BITS-1:0] CFG_ROW_COUNT = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_COL_COUNT = 2'd1;

	// Reset value of both count registers.
	localparam logic [COUNT_BITS-1:0] COUNT_RESET = 5'd16;

	typedef struct packed {
		logic [1:0]                   func;
		logic [ROW_BITS-1:0]          load_row;
		logic [COL_BITS-1:0]          load_col;
		logic signed [VALUE_BITS-1:0] load_value;
	} in_item_t;

	typedef struct packed {
		logic signed [VALUE_BITS-1:0] out_value;
		logic [ROW_BITS-1:0]          out_row;
		logic [COL_BITS-1:0]          out_col;
		logic                         is_last;
	} out_item_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic do_load;
		logic do_read;
		logic do_restart;
	} dzr_cmd_t;

endpackage

// ----- design/dzr_ctrl.sv -----
`timescale 1ns / 1ps

module dzr_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic [1:0]     func,
	output logic           in_stall,
	output logic           out_valid,
	input  logic           out_stall,
	output dzr_pkg::dzr_cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RESP = 2'b10
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   accept;

	// A new item may enter unless a result is waiting and stalled.
	assign in_stall  = (state_q == ST_RESP) && out_stall;
	assign out_valid = (state_q == ST_RESP);
	assign accept    = in_valid && !in_stall;

	// Decode the accepted item into datapath commands.
	always_comb begin
		cmd.do_load    = accept && (func == dzr_pkg::FUNC_LOAD);
		cmd.do_read    = accept && (func == dzr_pkg::FUNC_READ);
		cmd.do_restart = accept && (func == dzr_pkg::FUNC_RESTART);
	end

	// Next state: a read fills the result slot, taking the result empties it.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd.do_read)
					state_d = ST_RESP;
			end
			ST_RESP: begin
				if (cmd.do_read)
					state_d = ST_RESP;
				else if (!out_stall)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

endmodule

// ----- design/dzr_datapath.sv -----
`timescale 1ns / 1ps

module dzr_datapath (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  dzr_pkg::dzr_cmd_t                     cmd,
	input  dzr_pkg::in_item_t                     in_item,
	input  logic                                  cfg_we,
	input  logic [dzr_pkg::CFG_IDX_BITS-1:0]      cfg_index,
	input  logic [dzr_pkg::COUNT_BITS-1:0]        cfg_data,
	output dzr_pkg::out_item_t                    out_item
);

	logic [dzr_pkg::VALUE_BITS-1:0] mem [dzr_pkg::MAX_ROWS*dzr_pkg::MAX_COLS];
	logic [dzr_pkg::VALUE_BITS-1:0] rd_q;

	logic [dzr_pkg::COUNT_BITS-1:0] row_count_q;
	logic [dzr_pkg::COUNT_BITS-1:0] col_count_q;
	logic [dzr_pkg::COUNT_BITS-1:0] rows;
	logic [dzr_pkg::COUNT_BITS-1:0] cols;
	logic [dzr_pkg::ROW_BITS-1:0]   row_max;
	logic [dzr_pkg::COL_BITS-1:0]   col_max;

	logic [dzr_pkg::ROW_BITS-1:0]   walk_row_q;
	logic [dzr_pkg::COL_BITS-1:0]   walk_col_q;
	logic                           going_up_q;

	logic [dzr_pkg::ROW_BITS-1:0]   cur_row;
	logic [dzr_pkg::COL_BITS-1:0]   cur_col;
	logic                           cur_up;
	logic                           last;
	logic [dzr_pkg::ROW_BITS-1:0]   nxt_row;
	logic [dzr_pkg::COL_BITS-1:0]   nxt_col;
	logic                           nxt_up;

	logic [dzr_pkg::ROW_BITS-1:0]   res_row_q;
	logic [dzr_pkg::COL_BITS-1:0]   res_col_q;
	logic                           res_last_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q <= dzr_pkg::COUNT_RESET;
			col_count_q <= dzr_pkg::COUNT_RESET;
		end else if (cfg_we) begin
			if (cfg_index == dzr_pkg::CFG_ROW_COUNT)
				row_count_q <= cfg_data;
			if (cfg_index == dzr_pkg::CFG_COL_COUNT)
				col_count_q <= cfg_data;
		end
	end

	// Counts are clamped into the range the store can hold.
	always_comb begin
		if (row_count_q == '0)
			rows = dzr_pkg::COUNT_BITS'(1);
		else if (row_count_q > dzr_pkg::COUNT_BITS'(dzr_pkg::MAX_ROWS))
			rows = dzr_pkg::COUNT_BITS'(dzr_pkg::MAX_ROWS);
		else
			rows = row_count_q;
		if (col_count_q == '0)
			cols = dzr_pkg::COUNT_BITS'(1);
		else if (col_count_q > dzr_pkg::COUNT_BITS'(dzr_pkg::MAX_COLS))
			cols = dzr_pkg::COUNT_BITS'(dzr_pkg::MAX_COLS);
		else
			cols = col_count_q;
		row_max = dzr_pkg::ROW_BITS'(rows - 1'b1);
		col_max = dzr_pkg::COL_BITS'(cols - 1'b1);
	end

	// Walker position for this read; it restarts if the matrix shrank under it.
	always_comb begin
		if ({1'b0, walk_row_q} >= rows || {1'b0, walk_col_q} >= cols) begin
			cur_row = '0;
			cur_col = '0;
			cur_up  = 1'b1;
		end else begin
			cur_row = walk_row_q;
			cur_col = walk_col_q;
			cur_up  = going_up_q;
		end
		last = (cur_row == row_max) && (cur_col == col_max);
	end

	// Zigzag step: diagonal move inside, edge step with a turn at the border.
	always_comb begin
		nxt_row = cur_row;
		nxt_col = cur_col;
		nxt_up  = cur_up;
		if (last) begin
			nxt_row = '0;
			nxt_col = '0;
			nxt_up  = 1'b1;
		end else if (cur_up) begin
			if (cur_row != '0 && cur_col != col_max) begin
				nxt_row = cur_row - 1'b1;
				nxt_col = cur_col + 1'b1;
			end else begin
				if (cur_col != col_max)
					nxt_col = cur_col + 1'b1;
				else
					nxt_row = cur_row + 1'b1;
				nxt_up = 1'b0;
			end
		end else begin
			if (cur_row != row_max && cur_col != '0) begin
				nxt_row = cur_row + 1'b1;
				nxt_col = cur_col - 1'b1;
			end else begin
				if (cur_row != row_max)
					nxt_row = cur_row + 1'b1;
				else
					nxt_col = cur_col + 1'b1;
				nxt_up = 1'b1;
			end
		end
	end

	// Walker registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_row_q <= '0;
			walk_col_q <= '0;
			going_up_q <= 1'b1;
		end else if (cmd.do_restart) begin
			walk_row_q <= '0;
			walk_col_q <= '0;
			going_up_q <= 1'b1;
		end else if (cmd.do_read) begin
			walk_row_q <= nxt_row;
			walk_col_q <= nxt_col;
			going_up_q <= nxt_up;
		end
	end

	// Element store: one write port for loads, one registered read port.
	always_ff @(posedge clk) begin
		if (cmd.do_load)
			mem[{in_item.load_row, in_item.load_col}] <= in_item.load_value;
		if (cmd.do_read)
			rd_q <= mem[{cur_row, cur_col}];
	end

	// Coordinates and last flag of the pending result.
	always_ff @(posedge clk) begin
		if (cmd.do_read) begin
			res_row_q  <= cur_row;
			res_col_q  <= cur_col;
			res_last_q <= last;
		end
	end

	always_comb begin
		out_item.out_value = rd_q;
		out_item.out_row   = res_row_q;
		out_item.out_col   = res_col_q;
		out_item.is_last   = res_last_q;
	end

endmodule

// ----- design/diagonal_zigzag_reader.sv -----
`timescale 1ns / 1ps

// Zigzag diagonal matrix reader.
// Items enter on in_item with in_valid/in_stall: a load item writes one element
// of a 16 x 16 store, a read item returns the next element of the zigzag walk,
// and a restart item sends the walker back to the top-left corner going up.
// Results leave on out_item with out_valid/out_stall, one per read item only.
// The matrix size in use is set through the cfg port (index 0 rows, index 1
// columns), which is always ready; the user must write it only while the block
// is idle; the block itself does not enforce it. A read result appears in the
// cycle after the read item is accepted; the store has a registered read port.
// Items are taken every cycle while the result slot drains, so the sustained
// rate is one item per cycle. While out_stall holds a waiting result, in_stall
// is raised and the result stays unchanged.
// Reset clears the walker to the top-left corner going up and sets both counts
// to 16. The store contents are not cleared; read only elements that were
// loaded.

module diagonal_zigzag_reader (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  dzr_pkg::in_item_t                    in_item,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output dzr_pkg::out_item_t                   out_item,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [dzr_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  logic [dzr_pkg::COUNT_BITS-1:0]       cfg_data
);

	dzr_pkg::dzr_cmd_t cmd;

	assign cfg_ready = 1'b1;

	// Handshake and sequencing.
	dzr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.func      (in_item.func),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	// Store, walker and result registers.
	dzr_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_item   (in_item),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_item  (out_item)
	);

endmodule

// ----- verif/diagonal_zigzag_reader_tb.sv -----
`timescale 1ns / 1ps

module diagonal_zigzag_reader_tb;

	import dzr_pkg::*;

	// The one function code that the block leaves unused.
	localparam logic [1:0] FUNC_UNUSED = 2'd3;

	// Cycles with no handshake at all before the run is given up.
	localparam int unsigned QUIET_LIMIT = 2000;
	// Cycles allowed after the last result for a load or restart still in flight.
	localparam int SETTLE_CYCLES = 3;
	// Items sent per idling phase, including loads made ahead of reads.
	localparam int unsigned PHASE_ITEMS = 108;
	// Random items between changes of the matrix size.
	localparam int ITEMS_PER_SIZE = 40;

	// Shadow of the matrix store and the walker, with the queue of elements due out.
	class zigzag_scoreboard;
		logic signed [VALUE_BITS-1:0] elements [MAX_ROWS][MAX_COLS];
		bit                           loaded [MAX_ROWS][MAX_COLS];
		int unsigned                  walk_row;
		int unsigned                  walk_col;
		bit                           going_up;
		logic [COUNT_BITS-1:0]        row_reg;
		logic [COUNT_BITS-1:0]        col_reg;
		out_item_t                    expected_elements [$];
		int                           mismatches;

		function new();
			foreach (loaded[r, c])
				loaded[r][c] = 1'b0;
			restart_walk();
			row_reg    = COUNT_RESET;
			col_reg    = COUNT_RESET;
			mismatches = 0;
		endfunction

		function void restart_walk();
			walk_row = 0;
			walk_col = 0;
			going_up = 1'b1;
		endfunction

		// A count of zero behaves as one, and anything above the store size as the maximum.
		function int unsigned clamp(logic [COUNT_BITS-1:0] count_val, int unsigned top);
			if (count_val == 0)
				return 1;
			if (count_val > top)
				return top;
			return count_val;
		endfunction

		function int unsigned rows_in_use();
			return clamp(row_reg, MAX_ROWS);
		endfunction

		function int unsigned cols_in_use();
			return clamp(col_reg, MAX_COLS);
		endfunction

		function void write_count(logic [CFG_IDX_BITS-1:0] idx, logic [COUNT_BITS-1:0] val);
			if (idx == CFG_ROW_COUNT)
				row_reg = val;
			else if (idx == CFG_COL_COUNT)
				col_reg = val;
		endfunction

		// Position that the next read will visit, after any restart for a shrunk matrix.
		function void next_read_pos(output int unsigned r, output int unsigned c);
			if (walk_row >= rows_in_use() || walk_col >= cols_in_use()) begin
				r = 0;
				c = 0;
			end else begin
				r = walk_row;
				c = walk_col;
			end
		endfunction

		function int unsigned outstanding();
			return expected_elements.size();
		endfunction

		// Applies one accepted item and queues the element that a read will produce.
		function void accept_item(in_item_t item);
			int unsigned rows;
			int unsigned cols;
			int unsigned r;
			int unsigned c;
			bit          last;
			out_item_t   due;
			rows = rows_in_use();
			cols = cols_in_use();
			case (item.func)
				FUNC_LOAD: begin
					elements[item.load_row][item.load_col] = item.load_value;
					loaded[item.load_row][item.load_col]   = 1'b1;
				end
				FUNC_RESTART: begin
					restart_walk();
				end
				FUNC_READ: begin
					// A walker left outside a shrunk matrix starts again at the corner.
					if (walk_row >= rows || walk_col >= cols)
						restart_walk();
					r    = walk_row;
					c    = walk_col;
					last = (r == rows - 1) && (c == cols - 1);
					due.out_value = elements[r][c];
					due.out_row   = ROW_BITS'(r);
					due.out_col   = COL_BITS'(c);
					due.is_last   = last;
					expected_elements.push_back(due);
					// Step along the diagonal, or along the edge with a change of direction.
					if (last) begin
						restart_walk();
					end else if (going_up) begin
						if (r > 0 && c < cols - 1) begin
							walk_row = r - 1;
							walk_col = c + 1;
						end else begin
							if (c < cols - 1)
								walk_col = c + 1;
							else
								walk_row = r + 1;
							going_up = 1'b0;
						end
					end else begin
						if (r < rows - 1 && c > 0) begin
							walk_row = r + 1;
							walk_col = c - 1;
						end else begin
							if (r < rows - 1)
								walk_row = r + 1;
							else
								walk_col = c + 1;
							going_up = 1'b1;
						end
					end
				end
				// The unused code has no effect at all.
				default: ;
			endcase
		endfunction

		// Compares one result with the oldest element due out.
		function void check_element(out_item_t got);
			out_item_t due;
			if (expected_elements.size() == 0) begin
				$display("%0t: unexpected result: value %0d row %0d col %0d last %0b",
					$time, got.out_value, got.out_row, got.out_col, got.is_last);
				mismatches++;
				return;
			end
			due = expected_elements.pop_front();
			if (got.out_value !== due.out_value) begin
				$display("%0t: out_value expected %0d actual %0d",
					$time, due.out_value, got.out_value);
				mismatches++;
			end
			if (got.out_row !== due.out_row) begin
				$display("%0t: out_row expected %0d actual %0d", $time, due.out_row, got.out_row);
				mismatches++;
			end
			if (got.out_col !== due.out_col) begin
				$display("%0t: out_col expected %0d actual %0d", $time, due.out_col, got.out_col);
				mismatches++;
			end
			if (got.is_last !== due.is_last) begin
				$display("%0t: is_last expected %0b actual %0b", $time, due.is_last, got.is_last);
				mismatches++;
			end
		endfunction
	endclass

	logic                    clk;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_stall;
	in_item_t                in_item;
	logic                    out_valid;
	logic                    out_stall;
	out_item_t               out_item;
	logic                    cfg_valid;
	logic                    cfg_ready;
	logic [CFG_IDX_BITS-1:0] cfg_index;
	logic [COUNT_BITS-1:0]   cfg_data;

	zigzag_scoreboard sb;
	int               idle_pct = 0;
	int               stall_pct = 0;
	int unsigned      quiet_cycles = 0;
	int unsigned      items_sent = 0;

	diagonal_zigzag_reader dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// The receiver stalls at random, at the rate of the current phase.
	initial begin
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Every accepted result is checked against the oldest element due out.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_element(out_item);
	end

	// Ends the run if no handshake of any kind happens for too long.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("diagonal_zigzag_reader_tb NOT OK");
			$finish;
		end
	end

	function automatic in_item_t compose_item(logic [1:0] func, logic [ROW_BITS-1:0] row,
			logic [COL_BITS-1:0] col, logic [VALUE_BITS-1:0] value);
		in_item_t item;
		item.func       = func;
		item.load_row   = row;
		item.load_col   = col;
		item.load_value = value;
		return item;
	endfunction

	// Presents one item after a random gap and holds it until it is accepted.
	task automatic send_item(input in_item_t item);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= item;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.accept_item(item);
		items_sent++;
	endtask

	task automatic load_element(input logic [ROW_BITS-1:0] row, input logic [COL_BITS-1:0] col,
			input logic [VALUE_BITS-1:0] value);
		send_item(compose_item(FUNC_LOAD, row, col, value));
	endtask

	// Reads the next element, loading it first if it has never been written.
	task automatic read_next();
		int unsigned r;
		int unsigned c;
		sb.next_read_pos(r, c);
		if (!sb.loaded[r][c])
			load_element(ROW_BITS'(r), COL_BITS'(c), $urandom());
		send_item(compose_item(FUNC_READ, ROW_BITS'($urandom()), COL_BITS'($urandom()),
			$urandom()));
	endtask

	// Holds the sender off until every result is in and the pipeline has settled.
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	task automatic write_count(input logic [CFG_IDX_BITS-1:0] idx,
			input logic [COUNT_BITS-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.write_count(idx, val);
	endtask

	// Changes the matrix size only while the block is idle.
	task automatic set_counts(input logic [COUNT_BITS-1:0] rows,
			input logic [COUNT_BITS-1:0] cols);
		wait_drained();
		write_count(CFG_ROW_COUNT, rows);
		write_count(CFG_COL_COUNT, cols);
		cfg_valid <= 1'b0;
	endtask

	// Mostly small sizes so that walks complete, with zero and oversized counts now and then.
	function automatic logic [COUNT_BITS-1:0] pick_count();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 70)
			return COUNT_BITS'($urandom_range(1, 5));
		if (roll < 80)
			return '0;
		if (roll < 90)
			return COUNT_BITS'($urandom_range(6, MAX_ROWS));
		return COUNT_BITS'($urandom_range(MAX_ROWS + 1, 31));
	endfunction

	// One random item, weighted towards reads.
	task automatic random_item();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 60) begin
			read_next();
		end else if (roll < 80) begin
			load_element(ROW_BITS'($urandom_range(0, sb.rows_in_use() - 1)),
				COL_BITS'($urandom_range(0, sb.cols_in_use() - 1)), $urandom());
		end else if (roll < 88) begin
			load_element(ROW_BITS'($urandom()), COL_BITS'($urandom()), $urandom());
		end else if (roll < 94) begin
			send_item(compose_item(FUNC_RESTART, ROW_BITS'($urandom()), COL_BITS'($urandom()),
				$urandom()));
		end else begin
			send_item(compose_item(FUNC_UNUSED, ROW_BITS'($urandom()), COL_BITS'($urandom()),
				$urandom()));
		end
	endtask

	task automatic run_phase(input int sender_idle, input int recv_stall);
		int unsigned start_count;
		int          picks;
		start_count = items_sent;
		picks       = 0;
		idle_pct    = sender_idle;
		stall_pct   = recv_stall;
		while (items_sent - start_count < PHASE_ITEMS) begin
			if (picks % ITEMS_PER_SIZE == 0)
				set_counts(pick_count(), pick_count());
			random_item();
			picks++;
		end
	endtask

	initial begin
		sb        = new();
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_item   = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_ROW_COUNT;
		cfg_data  = COUNT_RESET;
		repeat (4)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Value extremes around the top-left corner, read in walk order.
		load_element(4'd0, 4'd0, 32'h7FFF_FFFF);
		load_element(4'd0, 4'd1, 32'h8000_0000);
		load_element(4'd1, 4'd0, 32'hFFFF_FFFF);
		repeat (3)
			read_next();

		// The unused code must not overwrite the corner; a restart goes back to it.
		send_item(compose_item(FUNC_UNUSED, 4'h0, 4'h0, 32'h5555_AAAA));
		send_item(compose_item(FUNC_RESTART, 4'hF, 4'hF, 32'hFFFF_FFFF));
		repeat (4)
			read_next();

		// A single-element matrix, reached with the walker left outside it.
		set_counts(5'd1, 5'd1);
		repeat (2)
			read_next();

		// Zero counts behave as one, oversized counts as the full store.
		set_counts('0, '0);
		read_next();
		set_counts(5'd31, 5'd31);
		read_next();
		set_counts(COUNT_RESET, COUNT_RESET);
		read_next();

		// Random phases with differing amounts of idling on each side.
		run_phase(0, 0);
		run_phase(70, 0);
		run_phase(0, 70);
		run_phase(30, 30);

		wait_drained();
		if (sb.mismatches == 0 && sb.outstanding() == 0)
			$display("diagonal_zigzag_reader_tb OK");
		else
			$display("diagonal_zigzag_reader_tb NOT OK");
		$finish;
	end

endmodule
